// ===== rtl/mpi_pkg.sv =====
// Shared constants, types and the control program of the modular power unit.
// Used by mpi_modmul and modular_power_and_inverse; depends on nothing.
`default_nettype none

package mpi_pkg;

	localparam int unsigned VAL_W = 20;
	localparam int unsigned EXP_W = 63;
	localparam int unsigned EREG_W = 64;
	localparam int unsigned PROD_W = 2 * VAL_W;
	localparam int unsigned RED_W = VAL_W + 2;
	localparam int unsigned PC_W = 3;
	localparam int unsigned CNT_W = 5;

	localparam logic OP_POWER = 1'b0;
	localparam logic OP_INVERSE = 1'b1;

	localparam logic [VAL_W-1:0] MOD_VAL = 20'd1000003;
	localparam logic [VAL_W-1:0] ORDER_VAL = 20'd1000002;
	localparam logic [VAL_W-1:0] INV_EXP = 20'd1000001;
	localparam logic [VAL_W:0] RECIP = 21'd1099508;
	localparam logic [CNT_W-1:0] RED_LAST = 5'd31;

	localparam logic [PC_W-1:0] PC_IDLE = 3'd0;
	localparam logic [PC_W-1:0] PC_RED = 3'd1;
	localparam logic [PC_W-1:0] PC_TEST = 3'd2;
	localparam logic [PC_W-1:0] PC_MUL = 3'd3;
	localparam logic [PC_W-1:0] PC_SQR = 3'd4;
	localparam logic [PC_W-1:0] PC_WAIT = 3'd5;
	localparam logic [PC_W-1:0] PC_LOOP = 3'd6;
	localparam logic [PC_W-1:0] PC_DONE = 3'd7;

	localparam logic [2:0] C_NONE = 3'd0;
	localparam logic [2:0] C_ALWAYS = 3'd1;
	localparam logic [2:0] C_NSTART = 3'd2;
	localparam logic [2:0] C_CNT = 3'd3;
	localparam logic [2:0] C_EZERO = 3'd4;
	localparam logic [2:0] C_BUSY = 3'd5;

	typedef struct packed {
		logic valid;
		logic dest_sq;
		logic wr_en;
	} mul_tag_t;

	typedef struct packed {
		logic issue;
		logic dest_sq;
		logic shift_e;
		logic red_step;
		logic done;
		logic [2:0] cond;
		logic [PC_W-1:0] target;
	} uop_t;

	function automatic uop_t ucode(input logic [PC_W-1:0] pc);
		uop_t u;
		u = '0;
		case (pc)
			PC_IDLE: begin
				u.cond = C_NSTART;
				u.target = PC_IDLE;
			end
			PC_RED: begin
				u.red_step = 1'b1;
				u.cond = C_CNT;
				u.target = PC_RED;
			end
			PC_TEST: begin
				u.cond = C_EZERO;
				u.target = PC_DONE;
			end
			PC_MUL: begin
				u.issue = 1'b1;
			end
			PC_SQR: begin
				u.issue = 1'b1;
				u.dest_sq = 1'b1;
				u.shift_e = 1'b1;
			end
			PC_WAIT: begin
				u.cond = C_BUSY;
				u.target = PC_WAIT;
			end
			PC_LOOP: begin
				u.cond = C_ALWAYS;
				u.target = PC_TEST;
			end
			PC_DONE: begin
				u.done = 1'b1;
				u.cond = C_ALWAYS;
				u.target = PC_IDLE;
			end
			default: begin
				u.cond = C_ALWAYS;
				u.target = PC_IDLE;
			end
		endcase
		return u;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/modular_power_and_inverse.sv =====
// Top level: modular power and inverse modulo 1000003, run by a microcoded sequencer.
// Depends on mpi_pkg and mpi_modmul.
//
//   channel   handshake          fields
//   command   start / busy       op, base, exponent
//   result    done (strobe)      result
//
// A transaction is accepted when start is high and busy is low.
// The exponent is first reduced modulo 1000002 two bits per cycle.
// Each remaining exponent bit then costs a multiply and a square on the shared
// three-stage modular multiplier; the sequencer waits for both to drain before
// it takes the next bit. The reduced exponent is at most 20 bits long.
// The result is shown for one cycle with done; the receiver cannot stall it.
// Reset clears the sequencer; no clearing pass is needed.
`default_nettype none

module modular_power_and_inverse
	import mpi_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic             op,
	input  wire logic [VAL_W-1:0] base,
	input  wire logic [EXP_W-1:0] exponent,
	output logic                  done,
	output logic [VAL_W-1:0]      result
);

	localparam logic [RED_W-1:0] ORD_X1 = RED_W'(ORDER_VAL);
	localparam logic [RED_W-1:0] ORD_X2 = RED_W'(2 * ORDER_VAL);
	localparam logic [RED_W-1:0] ORD_X3 = RED_W'(3 * ORDER_VAL);

	logic [PC_W-1:0] pc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [EREG_W-1:0] e_q;
	logic [VAL_W-1:0] rem_q;
	logic [VAL_W-1:0] acc_q;
	logic [VAL_W-1:0] sq_q;

	uop_t uop;
	logic accept;
	logic take;
	logic [PC_W-1:0] pc_next;
	logic [RED_W-1:0] red_v;
	logic [RED_W-1:0] red_r;
	mul_tag_t issue_tag;
	mul_tag_t wb_tag;
	logic [VAL_W-1:0] mul_a;
	logic [VAL_W-1:0] wb_val;
	logic pipe_busy;

	assign uop = ucode(pc_q);
	assign accept = start && !busy;

	always_comb begin
		case (uop.cond)
			C_NONE: take = 1'b0;
			C_ALWAYS: take = 1'b1;
			C_NSTART: take = !start;
			C_CNT: take = (cnt_q != '0);
			C_EZERO: take = (rem_q == '0);
			C_BUSY: take = pipe_busy;
			default: take = 1'b1;
		endcase
		pc_next = take ? uop.target : pc_q + PC_W'(1);
	end

	always_comb begin
		red_v = {rem_q, e_q[EREG_W-1:EREG_W-2]};
		if (red_v >= ORD_X3) begin
			red_r = red_v - ORD_X3;
		end else if (red_v >= ORD_X2) begin
			red_r = red_v - ORD_X2;
		end else if (red_v >= ORD_X1) begin
			red_r = red_v - ORD_X1;
		end else begin
			red_r = red_v;
		end
	end

	always_comb begin
		issue_tag.valid = uop.issue;
		issue_tag.dest_sq = uop.dest_sq;
		issue_tag.wr_en = uop.dest_sq | rem_q[0];
		mul_a = uop.dest_sq ? sq_q : acc_q;
	end

	mpi_modmul u_modmul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tag    (issue_tag),
		.a         (mul_a),
		.b         (sq_q),
		.out_tag   (wb_tag),
		.r         (wb_val),
		.pipe_busy (pipe_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_IDLE;
			cnt_q <= '0;
		end else begin
			pc_q <= pc_next;
			if (accept) begin
				cnt_q <= RED_LAST;
			end else if (uop.red_step && cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			e_q <= (op == OP_INVERSE) ? EREG_W'(INV_EXP) : EREG_W'(exponent);
			rem_q <= '0;
			acc_q <= VAL_W'(1);
			sq_q <= (base >= MOD_VAL) ? base - MOD_VAL : base;
		end else begin
			if (uop.red_step) begin
				e_q <= {e_q[EREG_W-3:0], 2'b00};
				rem_q <= red_r[VAL_W-1:0];
			end else if (uop.shift_e) begin
				rem_q <= {1'b0, rem_q[VAL_W-1:1]};
			end
			if (wb_tag.valid && wb_tag.wr_en) begin
				if (wb_tag.dest_sq) begin
					sq_q <= wb_val;
				end else begin
					acc_q <= wb_val;
				end
			end
		end
	end

	assign busy = (pc_q != PC_IDLE);
	assign done = uop.done;
	assign result = acc_q;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a transaction");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	a_done_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result < MOD_VAL)
		else $error("result not reduced below the modulus");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !pipe_busy)
		else $error("sequencer did not return to idle after the result");

endmodule

`default_nettype wire

// ===== rtl/mpi_modmul.sv =====
// Pipelined multiplier modulo 1000003 with Barrett reduction, three register stages.
// Depends on mpi_pkg for the modulus, the reciprocal and the tag type.
`default_nettype none

module mpi_modmul
	import mpi_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mul_tag_t         in_tag,
	input  wire logic [VAL_W-1:0] a,
	input  wire logic [VAL_W-1:0] b,
	output mul_tag_t              out_tag,
	output logic [VAL_W-1:0]      r,
	output logic                  pipe_busy
);

	localparam logic [RED_W-1:0] MOD_X1 = RED_W'(MOD_VAL);
	localparam logic [RED_W-1:0] MOD_X2 = RED_W'(2 * MOD_VAL);

	mul_tag_t tag_s1, tag_s2, tag_s3;
	logic [PROD_W-1:0] p_s1, p_s2;
	logic [VAL_W:0] q_s2;
	logic [RED_W-1:0] r_s3;

	logic [PROD_W-1:0] prod_c;
	logic [PROD_W+1:0] qest_c;
	logic [PROD_W:0] qm_c;
	logic [RED_W-1:0] rem_c;

	assign prod_c = a * b;
	assign qest_c = p_s1[PROD_W-1:VAL_W-1] * RECIP;
	assign qm_c = q_s2 * MOD_VAL;
	assign rem_c = p_s2[RED_W-1:0] - qm_c[RED_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s1 <= in_tag;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_s1 <= prod_c;
		p_s2 <= p_s1;
		q_s2 <= qest_c[PROD_W+1:VAL_W+1];
		r_s3 <= rem_c;
	end

	always_comb begin
		if (r_s3 >= MOD_X2) begin
			r = VAL_W'(r_s3 - MOD_X2);
		end else if (r_s3 >= MOD_X1) begin
			r = VAL_W'(r_s3 - MOD_X1);
		end else begin
			r = r_s3[VAL_W-1:0];
		end
	end

	assign out_tag = tag_s3;
	assign pipe_busy = tag_s1.valid | tag_s2.valid | tag_s3.valid;

endmodule

`default_nettype wire
